### hdl/i2cm_pkg.sv
// i2cm_pkg: shared types and constants for the i2c bit-level master
// used by i2cm_core, i2cm_out_stage and i2c_bit_level_master
package i2cm_pkg;

    localparam int BYTE_BITS  = 8;
    localparam int BIT_CNT_W  = 4;
    localparam int PHASE_W    = 3;
    localparam int DELAY_W    = 16;
    localparam int POLL_W     = 8;
    localparam int CMD_W      = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CMD_W-1:0] OP_IDLE    = 3'd0;
    localparam logic [CMD_W-1:0] OP_START   = 3'd1;
    localparam logic [CMD_W-1:0] OP_STOP    = 3'd2;
    localparam logic [CMD_W-1:0] OP_WRITE   = 3'd3;
    localparam logic [CMD_W-1:0] OP_WAITACK = 3'd4;
    localparam logic [CMD_W-1:0] OP_READ    = 3'd5;

    localparam logic CFG_PHASE_DELAY = 1'b0;
    localparam logic CFG_ACK_POLL    = 1'b1;

    localparam logic [DELAY_W-1:0] PHASE_DELAY_RESET = 16'd800;
    localparam logic [POLL_W-1:0]  ACK_POLL_RESET    = 8'd250;

    typedef struct packed {
        logic                 scl;
        logic                 sda;
        logic                 busy;
        logic                 done;
        logic [BYTE_BITS-1:0] rx_byte;
        logic                 ack_missing;
    } result_t;

endpackage

### hdl/i2cm_core.sv
// i2cm_core: command sequencer state, config registers and per-tick next-state logic
// depends on i2cm_pkg
module i2cm_core
    import i2cm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [BYTE_BITS-1:0]  tx_byte,
    input  logic                  give_ack,
    input  logic                  sda_level,
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output result_t               res
);

    logic [DELAY_W-1:0]   phase_delay_reg;
    logic [POLL_W-1:0]    poll_limit_reg;

    logic [CMD_W-1:0]     op_reg, op_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [BYTE_BITS-1:0] shift_reg, shift_next;
    logic [DELAY_W-1:0]   delay_reg, delay_next;
    logic [POLL_W-1:0]    poll_cnt_reg, poll_cnt_next;
    logic                 ack_choice_reg, ack_choice_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic                 ack_err_reg, ack_err_next;
    logic [BYTE_BITS-1:0] rx_hold_reg, rx_hold_next;
    logic                 done_next;

    logic [DELAY_W-1:0]   hold_delay;
    logic [BIT_CNT_W-1:0] bit_cnt_inc;
    logic [BYTE_BITS-1:0] shift_left;

    assign hold_delay  = (phase_delay_reg == '0) ? '0 : phase_delay_reg - DELAY_W'(1);
    assign bit_cnt_inc = bit_cnt_reg + BIT_CNT_W'(1);
    assign shift_left  = {shift_reg[BYTE_BITS-2:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_delay_reg <= PHASE_DELAY_RESET;
            poll_limit_reg  <= ACK_POLL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_PHASE_DELAY: phase_delay_reg <= cfg_wdata[DELAY_W-1:0];
                CFG_ACK_POLL:    poll_limit_reg  <= cfg_wdata[POLL_W-1:0];
                default:         phase_delay_reg <= phase_delay_reg;
            endcase
        end
    end

    always_comb
    begin
        op_next         = op_reg;
        phase_next      = phase_reg;
        bit_cnt_next    = bit_cnt_reg;
        shift_next      = shift_reg;
        delay_next      = delay_reg;
        poll_cnt_next   = poll_cnt_reg;
        ack_choice_next = ack_choice_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        ack_err_next    = ack_err_reg;
        rx_hold_next    = rx_hold_reg;
        done_next       = 1'b0;

        if (op_reg == OP_IDLE)
        begin
            // command accept
            if (cmd >= OP_START && cmd <= OP_READ)
            begin
                bit_cnt_next = '0;
                op_next      = cmd;
                phase_next   = '0;
                delay_next   = hold_delay;
            end
            unique case (cmd)
                OP_START:
                begin
                    sda_next = 1'b1;
                    scl_next = 1'b1;
                end
                OP_STOP:
                begin
                    sda_next = 1'b0;
                end
                OP_WRITE:
                begin
                    shift_next = tx_byte;
                    sda_next   = tx_byte[BYTE_BITS-1];
                end
                OP_WAITACK:
                begin
                    poll_cnt_next = '0;
                    ack_err_next  = 1'b0;
                    sda_next      = 1'b1;
                end
                OP_READ:
                begin
                    ack_choice_next = give_ack;
                    shift_next      = '0;
                    sda_next        = 1'b1;
                    scl_next        = 1'b1;
                end
                default:
                begin
                    op_next = OP_IDLE;
                end
            endcase
        end
        else if (delay_reg != '0)
        begin
            delay_next = delay_reg - DELAY_W'(1);
        end
        else
        begin
            // phase end: default is to hold the next phase, finish overrides
            delay_next = hold_delay;
            unique case (op_reg)
                OP_START:
                begin
                    priority if (phase_reg == 3'd0)
                    begin
                        sda_next = 1'b0; phase_next = 3'd1;
                    end
                    else if (phase_reg == 3'd1)
                    begin
                        scl_next = 1'b0; phase_next = 3'd2;
                    end
                    else
                    begin
                        op_next = OP_IDLE; phase_next = '0; delay_next = '0; done_next = 1'b1;
                    end
                end
                OP_STOP:
                begin
                    priority if (phase_reg == 3'd0)
                    begin
                        scl_next = 1'b1; phase_next = 3'd1;
                    end
                    else if (phase_reg == 3'd1)
                    begin
                        sda_next = 1'b1; phase_next = 3'd2;
                    end
                    else
                    begin
                        op_next = OP_IDLE; phase_next = '0; delay_next = '0; done_next = 1'b1;
                    end
                end
                OP_WRITE:
                begin
                    priority if (phase_reg == 3'd0)
                    begin
                        scl_next = 1'b1; phase_next = 3'd1;
                    end
                    else if (phase_reg == 3'd1)
                    begin
                        scl_next = 1'b0; phase_next = 3'd2;
                    end
                    else
                    begin
                        shift_next   = shift_left;
                        bit_cnt_next = bit_cnt_inc;
                        if (bit_cnt_inc >= BIT_CNT_W'(BYTE_BITS))
                        begin
                            sda_next = 1'b1;
                            op_next = OP_IDLE; phase_next = '0; delay_next = '0;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            sda_next   = shift_left[BYTE_BITS-1];
                            phase_next = 3'd0;
                        end
                    end
                end
                OP_WAITACK:
                begin
                    priority if (phase_reg == 3'd0)
                    begin
                        scl_next = 1'b1; phase_next = 3'd1;
                    end
                    else if (phase_reg == 3'd1 || phase_reg == 3'd2)
                    begin
                        priority if (!sda_level)
                        begin
                            scl_next = 1'b0; phase_next = 3'd3;
                        end
                        else if (poll_cnt_reg >= poll_limit_reg)
                        begin
                            // timeout: drop scl then run a stop
                            scl_next = 1'b0; sda_next = 1'b0; phase_next = 3'd4;
                        end
                        else
                        begin
                            poll_cnt_next = poll_cnt_reg + POLL_W'(1);
                            phase_next    = 3'd2;
                        end
                    end
                    else if (phase_reg == 3'd3)
                    begin
                        op_next = OP_IDLE; phase_next = '0; delay_next = '0; done_next = 1'b1;
                    end
                    else if (phase_reg == 3'd4)
                    begin
                        scl_next = 1'b1; phase_next = 3'd5;
                    end
                    else if (phase_reg == 3'd5)
                    begin
                        sda_next = 1'b1; phase_next = 3'd6;
                    end
                    else
                    begin
                        ack_err_next = 1'b1;
                        op_next = OP_IDLE; phase_next = '0; delay_next = '0; done_next = 1'b1;
                    end
                end
                OP_READ:
                begin
                    priority if (phase_reg == 3'd0)
                    begin
                        shift_next = {shift_reg[BYTE_BITS-2:0], sda_level};
                        scl_next   = 1'b0;
                        phase_next = 3'd1;
                    end
                    else if (phase_reg == 3'd1)
                    begin
                        bit_cnt_next = bit_cnt_inc;
                        if (bit_cnt_inc >= BIT_CNT_W'(BYTE_BITS))
                        begin
                            sda_next   = !ack_choice_reg;
                            phase_next = 3'd2;
                        end
                        else
                        begin
                            scl_next   = 1'b1;
                            phase_next = 3'd0;
                        end
                    end
                    else if (phase_reg == 3'd2)
                    begin
                        scl_next = 1'b1; phase_next = 3'd3;
                    end
                    else if (phase_reg == 3'd3)
                    begin
                        scl_next = 1'b0; phase_next = 3'd4;
                    end
                    else
                    begin
                        sda_next     = 1'b1;
                        rx_hold_next = shift_reg;
                        op_next = OP_IDLE; phase_next = '0; delay_next = '0; done_next = 1'b1;
                    end
                end
                default:
                begin
                    op_next = OP_IDLE; phase_next = '0; delay_next = '0; done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg         <= OP_IDLE;
            phase_reg      <= '0;
            bit_cnt_reg    <= '0;
            shift_reg      <= '0;
            delay_reg      <= '0;
            poll_cnt_reg   <= '0;
            ack_choice_reg <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            ack_err_reg    <= 1'b0;
            rx_hold_reg    <= '0;
        end
        else if (step)
        begin
            op_reg         <= op_next;
            phase_reg      <= phase_next;
            bit_cnt_reg    <= bit_cnt_next;
            shift_reg      <= shift_next;
            delay_reg      <= delay_next;
            poll_cnt_reg   <= poll_cnt_next;
            ack_choice_reg <= ack_choice_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            ack_err_reg    <= ack_err_next;
            rx_hold_reg    <= rx_hold_next;
        end
    end

    assign res.scl         = scl_next;
    assign res.sda         = sda_next;
    assign res.busy        = (op_next != OP_IDLE);
    assign res.done        = done_next;
    assign res.rx_byte     = rx_hold_next;
    assign res.ack_missing = ack_err_next;

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (op_reg == OP_IDLE) |-> (phase_reg == '0 && delay_reg == '0))
        else $error("idle with phase or delay pending");

    a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_cnt_reg <= BIT_CNT_W'(BYTE_BITS))
        else $error("bit counter past byte length");

    a_delay_countdown: assert property (@(posedge clk) disable iff (!rst_n)
        (step && op_reg != OP_IDLE && delay_reg != '0)
            |=> (delay_reg == $past(delay_reg) - DELAY_W'(1) && op_reg == $past(op_reg)))
        else $error("phase delay did not count down");

    a_cmd_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (step && op_reg == OP_IDLE && cmd >= OP_START && cmd <= OP_READ)
            |=> (op_reg == $past(cmd) && phase_reg == '0))
        else $error("command not taken while idle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && done_next) |=> (op_reg == OP_IDLE))
        else $error("done without returning to idle");

endmodule

### hdl/i2cm_out_stage.sv
// i2cm_out_stage: result register with valid/ready handshake toward the consumer
// depends on i2cm_pkg
module i2cm_out_stage
    import i2cm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res_in,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t res_out
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign space      = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = data_reg;

endmodule

### hdl/i2c_bit_level_master.sv
// i2c_bit_level_master: tick-driven i2c master sequencer, top level
// output: each tick's result is registered and offered in the cycle after its input transaction
// throughput: one tick per cycle while out_ready keeps the single result register free
// reset: bus released (scl and sda high), idle, phase delay 800, ack poll limit 250
// depends on i2cm_pkg, i2cm_core, i2cm_out_stage
module i2c_bit_level_master
    import i2cm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [BYTE_BITS-1:0]  tx_byte,
    input  logic                  give_ack,
    input  logic                  sda_level,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  scl_drive,
    output logic                  sda_drive,
    output logic                  busy_res,
    output logic                  done_res,
    output logic [BYTE_BITS-1:0]  rx_byte,
    output logic                  ack_missing,
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic    step;
    logic    space;
    result_t res_comb;
    result_t res_q;

    assign in_ready = space;
    assign step     = in_valid && space;

    i2cm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .cmd       (cmd),
        .tx_byte   (tx_byte),
        .give_ack  (give_ack),
        .sda_level (sda_level),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .res       (res_comb)
    );

    i2cm_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .res_in    (res_comb),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (res_q)
    );

    assign scl_drive   = res_q.scl;
    assign sda_drive   = res_q.sda;
    assign busy_res    = res_q.busy;
    assign done_res    = res_q.done;
    assign rx_byte     = res_q.rx_byte;
    assign ack_missing = res_q.ack_missing;

endmodule

### sim/tb.sv
// tb: self-checking bench for the tick-driven i2c bit-level master
// predicts scl, sda and status per tick and compares every result transaction
// depends on i2cm_pkg and i2c_bit_level_master
module tb;
    import i2cm_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned RANDOM_TICKS = 500;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [CMD_W-1:0]      cmd = OP_IDLE;
    logic [BYTE_BITS-1:0]  tx_byte = '0;
    logic                  give_ack = 1'b0;
    logic                  sda_level = 1'b1;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  scl_drive;
    logic                  sda_drive;
    logic                  busy_res;
    logic                  done_res;
    logic [BYTE_BITS-1:0]  rx_byte;
    logic                  ack_missing;
    logic                  cfg_we = 1'b0;
    logic                  cfg_addr = CFG_PHASE_DELAY;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // predicted sequencer state
    logic [CMD_W-1:0]     op_q = OP_IDLE;
    logic [3:0]           phase_q = '0;
    logic [BIT_CNT_W-1:0] bits_q = '0;
    logic [BYTE_BITS-1:0] shreg_q = '0;
    logic [DELAY_W-1:0]   wait_q = '0;
    logic [POLL_W-1:0]    polls_q = '0;
    logic                 ack_sel_q = 1'b0;
    logic                 scl_q = 1'b1;
    logic                 sda_q = 1'b1;
    logic                 ack_err_q = 1'b0;
    logic                 done_q = 1'b0;
    logic [BYTE_BITS-1:0] rx_q = '0;
    logic [DELAY_W-1:0]   cfg_delay = PHASE_DELAY_RESET;
    logic [POLL_W-1:0]    cfg_polls = ACK_POLL_RESET;

    result_t     pin_expect[$];
    int unsigned ticks_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned hold_asks = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    bit          calm = 1'b0;

    i2c_bit_level_master dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .tx_byte     (tx_byte),
        .give_ack    (give_ack),
        .sda_level   (sda_level),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .scl_drive   (scl_drive),
        .sda_drive   (sda_drive),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .rx_byte     (rx_byte),
        .ack_missing (ack_missing),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic void reload(input logic [3:0] nxt);
        phase_q = nxt;
        wait_q = (cfg_delay == 0) ? '0 : cfg_delay - 16'd1;
    endfunction

    function automatic void wrap_up();
        op_q = OP_IDLE;
        phase_q = '0;
        wait_q = '0;
        done_q = 1'b1;
    endfunction

    // one tick of the sequencer, pushes the expected pin and status levels
    function automatic void step_sequencer(input logic [CMD_W-1:0] c,
                                           input logic [BYTE_BITS-1:0] b,
                                           input logic a, input logic s);
        result_t r;
        bit      taken;
        taken = 1'b1;
        done_q = 1'b0;
        if (op_q == OP_IDLE)
        begin
            bits_q = '0;
            case (c)
                OP_START:
                begin
                    sda_q = 1'b1;
                    scl_q = 1'b1;
                end
                OP_STOP: sda_q = 1'b0;
                OP_WRITE:
                begin
                    shreg_q = b;
                    sda_q = b[BYTE_BITS-1];
                end
                OP_WAITACK:
                begin
                    polls_q = '0;
                    ack_err_q = 1'b0;
                    sda_q = 1'b1;
                end
                OP_READ:
                begin
                    ack_sel_q = a;
                    shreg_q = '0;
                    sda_q = 1'b1;
                    scl_q = 1'b1;
                end
                default: taken = 1'b0;
            endcase
            if (taken)
            begin
                op_q = c;
                reload(0);
            end
        end
        else if (wait_q != 0)
            wait_q = wait_q - 16'd1;
        else
        begin
            case (op_q)
                OP_START:
                    if (phase_q == 0)
                    begin
                        sda_q = 1'b0;
                        reload(1);
                    end
                    else if (phase_q == 1)
                    begin
                        scl_q = 1'b0;
                        reload(2);
                    end
                    else
                        wrap_up();
                OP_STOP:
                    if (phase_q == 0)
                    begin
                        scl_q = 1'b1;
                        reload(1);
                    end
                    else if (phase_q == 1)
                    begin
                        sda_q = 1'b1;
                        reload(2);
                    end
                    else
                        wrap_up();
                OP_WRITE:
                    if (phase_q == 0)
                    begin
                        scl_q = 1'b1;
                        reload(1);
                    end
                    else if (phase_q == 1)
                    begin
                        scl_q = 1'b0;
                        reload(2);
                    end
                    else
                    begin
                        shreg_q = shreg_q << 1;
                        bits_q = bits_q + 1'b1;
                        if (bits_q >= BYTE_BITS)
                        begin
                            sda_q = 1'b1;
                            wrap_up();
                        end
                        else
                        begin
                            sda_q = shreg_q[BYTE_BITS-1];
                            reload(0);
                        end
                    end
                OP_WAITACK:
                    if (phase_q == 0)
                    begin
                        scl_q = 1'b1;
                        reload(1);
                    end
                    else if (phase_q == 1 || phase_q == 2)
                    begin
                        if (!s)
                        begin
                            scl_q = 1'b0;
                            reload(3);
                        end
                        else if (polls_q >= cfg_polls)
                        begin
                            // timeout: drop scl and run a stop
                            scl_q = 1'b0;
                            sda_q = 1'b0;
                            reload(4);
                        end
                        else
                        begin
                            polls_q = polls_q + 1'b1;
                            reload(2);
                        end
                    end
                    else if (phase_q == 3)
                        wrap_up();
                    else if (phase_q == 4)
                    begin
                        scl_q = 1'b1;
                        reload(5);
                    end
                    else if (phase_q == 5)
                    begin
                        sda_q = 1'b1;
                        reload(6);
                    end
                    else
                    begin
                        ack_err_q = 1'b1;
                        wrap_up();
                    end
                OP_READ:
                    if (phase_q == 0)
                    begin
                        shreg_q = {shreg_q[BYTE_BITS-2:0], s};
                        scl_q = 1'b0;
                        reload(1);
                    end
                    else if (phase_q == 1)
                    begin
                        bits_q = bits_q + 1'b1;
                        if (bits_q >= BYTE_BITS)
                        begin
                            sda_q = ack_sel_q ? 1'b0 : 1'b1;
                            reload(2);
                        end
                        else
                        begin
                            scl_q = 1'b1;
                            reload(0);
                        end
                    end
                    else if (phase_q == 2)
                    begin
                        scl_q = 1'b1;
                        reload(3);
                    end
                    else if (phase_q == 3)
                    begin
                        scl_q = 1'b0;
                        reload(4);
                    end
                    else
                    begin
                        sda_q = 1'b1;
                        rx_q = shreg_q;
                        wrap_up();
                    end
                default: wrap_up();
            endcase
        end
        r.scl = scl_q;
        r.sda = sda_q;
        r.busy = (op_q != OP_IDLE);
        r.done = done_q;
        r.rx_byte = rx_q;
        r.ack_missing = ack_err_q;
        pin_expect.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got_v,
                                   input logic [7:0] want_v);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch on %s at result %0d: got %h, expected %h",
                     what, results_seen, got_v, want_v);
    endtask

    // result side: check each transaction, random stalls, long hold on request
    always @(posedge clk)
    begin
        result_t want;
        if (out_valid === 1'b1 && out_ready)
        begin
            results_seen++;
            if (pin_expect.size() == 0)
                report_mismatch("result with nothing expected", 8'h0, 8'h0);
            else
            begin
                want = pin_expect.pop_front();
                if (scl_drive !== want.scl)
                    report_mismatch("scl_drive", 8'(scl_drive), 8'(want.scl));
                if (sda_drive !== want.sda)
                    report_mismatch("sda_drive", 8'(sda_drive), 8'(want.sda));
                if (busy_res !== want.busy)
                    report_mismatch("busy_res", 8'(busy_res), 8'(want.busy));
                if (done_res !== want.done)
                    report_mismatch("done_res", 8'(done_res), 8'(want.done));
                if (rx_byte !== want.rx_byte)
                    report_mismatch("rx_byte", rx_byte, want.rx_byte);
                if (ack_missing !== want.ack_missing)
                    report_mismatch("ack_missing", 8'(ack_missing), 8'(want.ack_missing));
            end
        end
        if (hold_seen != hold_asks)
        begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= calm || ($urandom_range(99) >= 15);
    end

    task automatic send_tick(input logic [CMD_W-1:0] c, input logic [BYTE_BITS-1:0] b,
                             input logic a, input logic s);
        if (!calm)
            while ($urandom_range(99) < 15)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        cmd <= c;
        tx_byte <= b;
        give_ack <= a;
        sda_level <= s;
        do
            @(posedge clk);
        while (!in_ready);
        ticks_sent++;
        step_sequencer(c, b, a, s);
    endtask

    // issue one command, then tick with noise commands until the bus goes idle;
    // the line answers reads from rd_bits and acks after ack_after high polls
    task automatic run_cmd(input logic [CMD_W-1:0] c, input logic [BYTE_BITS-1:0] b,
                           input logic a, input logic [BYTE_BITS-1:0] rd_bits,
                           input int unsigned ack_after);
        logic s;
        send_tick(c, b, a, 1'($urandom_range(1)));
        while (op_q != OP_IDLE)
        begin
            if (op_q == OP_READ && bits_q < BYTE_BITS)
                s = rd_bits[BYTE_BITS-1-bits_q];
            else if (op_q == OP_WAITACK)
                s = (polls_q >= ack_after) ? 1'b0 : 1'b1;
            else
                s = 1'($urandom_range(1));
            send_tick(3'($urandom_range(7)), 8'($urandom_range(255)),
                      1'($urandom_range(1)), s);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pin_expect.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic addr, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (addr == CFG_PHASE_DELAY)
            cfg_delay = data;
        else
            cfg_polls = data[POLL_W-1:0];
    endtask

    task automatic set_timing(input logic [DELAY_W-1:0] delay, input logic [POLL_W-1:0] polls);
        settle();
        write_reg(CFG_PHASE_DELAY, delay);
        write_reg(CFG_ACK_POLL, {8'($urandom_range(255)), polls});
    endtask

    // unknown commands at reset, then the reset ack poll limit with short phases
    task automatic test_reset_values();
        calm = 1'b1;
        run_cmd(3'd6, 8'h00, 1'b0, 8'h00, 0);
        run_cmd(3'd7, 8'hff, 1'b1, 8'h00, 0);
        run_cmd(OP_IDLE, 8'h5a, 1'b1, 8'h00, 0);
        settle();
        write_reg(CFG_PHASE_DELAY, 16'd1);
        run_cmd(OP_START, 8'h00, 1'b0, 8'h00, 0);
        run_cmd(OP_WAITACK, 8'h00, 1'b0, 8'h00, 251);
        run_cmd(OP_STOP, 8'h00, 1'b0, 8'h00, 0);
        calm = 1'b0;
    endtask

    task automatic test_write_bytes();
        set_timing(16'd1, 8'd0);
        run_cmd(OP_START, 8'h00, 1'b0, 8'h00, 0);
        run_cmd(OP_WRITE, 8'h00, 1'b0, 8'h00, 0);
        run_cmd(OP_WAITACK, 8'h00, 1'b0, 8'h00, 0);
        run_cmd(OP_WRITE, 8'hff, 1'b1, 8'h00, 0);
        run_cmd(OP_WAITACK, 8'h00, 1'b0, 8'h00, 1);
        run_cmd(OP_WRITE, 8'h80, 1'b0, 8'h00, 0);
        run_cmd(OP_WRITE, 8'h01, 1'b0, 8'h00, 0);
        run_cmd(OP_STOP, 8'h00, 1'b0, 8'h00, 0);
    endtask

    task automatic test_read_bytes();
        set_timing(16'd2, 8'd4);
        run_cmd(OP_READ, 8'h00, 1'b1, 8'ha5, 0);
        run_cmd(OP_READ, 8'hff, 1'b0, 8'h5a, 0);
        run_cmd(OP_READ, 8'h00, 1'b1, 8'hff, 0);
        run_cmd(OP_READ, 8'h00, 1'b0, 8'h00, 0);
    endtask

    task automatic test_ack_polling();
        set_timing(16'd1, 8'd1);
        run_cmd(OP_WAITACK, 8'h00, 1'b0, 8'h00, 1);
        run_cmd(OP_WAITACK, 8'h00, 1'b0, 8'h00, 2);
        set_timing(16'd1, 8'd255);
        run_cmd(OP_WAITACK, 8'h00, 1'b0, 8'h00, 256);
        run_cmd(OP_WAITACK, 8'h00, 1'b0, 8'h00, 0);
    endtask

    task automatic test_zero_delay();
        set_timing(16'd0, 8'd3);
        run_cmd(OP_START, 8'h00, 1'b0, 8'h00, 0);
        run_cmd(OP_WRITE, 8'($urandom_range(255)), 1'b0, 8'h00, 0);
        run_cmd(OP_WAITACK, 8'h00, 1'b0, 8'h00, 4);
        run_cmd(OP_READ, 8'h00, 1'b1, 8'($urandom_range(255)), 0);
        run_cmd(OP_STOP, 8'h00, 1'b0, 8'h00, 0);
    endtask

    task automatic test_long_delay();
        set_timing(16'd40, 8'd2);
        calm = 1'b1;
        run_cmd(OP_STOP, 8'h00, 1'b0, 8'h00, 0);
        calm = 1'b0;
    endtask

    task automatic test_back_pressure();
        set_timing(16'd2, 8'd2);
        hold_asks++;
        run_cmd(OP_START, 8'h00, 1'b0, 8'h00, 0);
        run_cmd(OP_WRITE, 8'($urandom_range(255)), 1'b0, 8'h00, 0);
        run_cmd(OP_WAITACK, 8'h00, 1'b0, 8'h00, 1);
        settle();
        run_cmd(OP_READ, 8'h00, 1'b0, 8'($urandom_range(255)), 0);
        run_cmd(OP_STOP, 8'h00, 1'b0, 8'h00, 0);
    endtask

    // well-formed bus transfers with random content, some stray commands
    task automatic test_random();
        int unsigned first;
        int unsigned span;
        int unsigned cfg_mark;
        int unsigned ack_after;
        logic [DELAY_W-1:0] delay;
        logic [POLL_W-1:0]  polls;
        first = ticks_sent;
        cfg_mark = 0;
        while (ticks_sent - first < RANDOM_TICKS)
        begin
            span = ticks_sent - first;
            if (span >= cfg_mark)
            begin
                delay = ($urandom_range(3) == 0) ? 16'($urandom_range(2, 3))
                                                 : 16'($urandom_range(1));
                polls = ($urandom_range(7) == 0) ? 8'd255 : 8'($urandom_range(6));
                set_timing(delay, polls);
                cfg_mark = span + 150;
            end
            calm = (span >= 150 && span < 300);
            if ($urandom_range(9) != 0)
                run_cmd(OP_START, 8'($urandom_range(255)), 1'($urandom_range(1)), 8'h00, 0);
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(3) == 0)
                    ack_after = cfg_polls + 1;
                else
                    ack_after = $urandom_range(0, (cfg_polls < 4) ? cfg_polls : 4);
                if ($urandom_range(9) == 0)
                    run_cmd(3'($urandom_range(7)), 8'($urandom_range(255)),
                            1'($urandom_range(1)), 8'($urandom_range(255)), ack_after);
                else if ($urandom_range(2) == 0)
                    run_cmd(OP_READ, 8'($urandom_range(255)), 1'($urandom_range(1)),
                            8'($urandom_range(255)), 0);
                else
                begin
                    run_cmd(OP_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                            8'h00, 0);
                    run_cmd(OP_WAITACK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                            8'h00, ack_after);
                end
            end
            if ($urandom_range(9) != 0)
                run_cmd(OP_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)), 8'h00, 0);
        end
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_write_bytes();
        test_read_bytes();
        test_ack_polling();
        test_zero_delay();
        test_long_delay();
        test_back_pressure();
        test_random();
        settle();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && pin_expect.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

### i2c_bit_level_master.f
hdl/i2cm_pkg.sv
hdl/i2cm_core.sv
hdl/i2cm_out_stage.sv
hdl/i2c_bit_level_master.sv
sim/tb.sv
